### hw/rtl/egwp_pkg.sv
// Package for the Elias gamma word packer.
// Holds the beat types and the shared constants; no dependencies.
package egwp_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned ValueBits = 16;
  localparam int unsigned UsedBits  = 6;
  localparam int unsigned CountBits = 16;
  localparam int unsigned PosBits   = 5;
  localparam int unsigned NBits     = 4;
  localparam int unsigned CodeBits  = 2 * ValueBits - 1;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrBits = 2;
  localparam int unsigned QueueCntBits = 3;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic                 end_of_block;
  } in_t;

  typedef struct packed {
    logic [WordBits-1:0]  packed_word;
    logic [UsedBits-1:0]  bits_used;
    logic                 last_word;
    logic [CountBits-1:0] total_words;
    logic                 value_error;
  } out_t;

endpackage

### hw/rtl/elias_gamma_word_packer.sv
// Top level of the Elias gamma word packer.
// Encodes values into gamma codes, packs them into 32-bit words and queues the results.
// Depends on egwp_pkg.
//
// Usage:
// The input channel (in_valid_i, in_ready_o, in_data_i) takes one value per beat,
// with end_of_block marking the last value of a block. The output channel
// (out_valid_o, out_ready_i, out_data_o) delivers full words, flush words, and
// error markers in order. Each input beat is encoded in the cycle that accepts it,
// and its zero to two results are written into a four-entry output queue. A result
// is registered in the queue and is read out after any earlier results. The block
// takes one input beat per cycle whenever the queue has room for two results. A
// beat that yields one result per cycle therefore sustains one beat per cycle
// against a receiver that never stalls. When the receiver stalls, the queue fills,
// and in_ready_o drops once fewer than two entries are free. Reset clears the
// partial word, the bit position, the word count, and the queue.
module elias_gamma_word_packer
  import egwp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic [WordBits-1:0]     partial_q, partial_d;
  logic [PosBits-1:0]      bit_pos_q, bit_pos_d;
  logic [CountBits-1:0]    word_total_q, word_total_d;

  out_t                    queue_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntBits-1:0] count_q, count_d;

  logic                    in_fire, out_fire;
  logic                    err;
  logic [NBits-1:0]        n;
  logic [ValueBits-1:0]    mask;
  logic [CodeBits-1:0]     code;
  logic [PosBits-1:0]      len;
  logic [PosBits:0]        sum;
  logic [2*WordBits-1:0]   wide;
  logic                    word_vld, fin_vld;
  logic [CountBits-1:0]    cnt_word, cnt_fin;
  logic [WordBits-1:0]     part_new;
  logic [PosBits-1:0]      pos_new;
  out_t                    res_a, res_b, word_res, fin_res;
  logic                    a_vld, b_vld;
  logic [QueueCntBits-1:0] push_cnt;

  function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] c);
    sat_inc = (c == CountMax) ? c : c + CountBits'(1);
  endfunction

  assign in_ready_o  = (count_q <= QueueCntBits'(QueueDepth - 2));
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign out_data_o  = queue_q[rd_ptr_q];

  always_comb begin
    err = (in_data_i.value == '0);
    n   = '0;
    for (int i = 0; i < ValueBits; i++) begin
      if (in_data_i.value[i]) begin
        n = NBits'(i);
      end
    end
    mask = (ValueBits'(1) << n) - ValueBits'(1);
    code = CodeBits'(mask) | (CodeBits'(in_data_i.value & mask) << (PosBits'(n) + PosBits'(1)));
    len  = {n, 1'b1};
    sum  = (PosBits+1)'(bit_pos_q) + (PosBits+1)'(len);
    wide = (2*WordBits)'(code) << bit_pos_q;

    word_vld = 1'b0;
    part_new = partial_q;
    pos_new  = bit_pos_q;
    cnt_word = word_total_q;
    if (!err) begin
      if (sum < (PosBits+1)'(WordBits)) begin
        part_new = partial_q | wide[WordBits-1:0];
        pos_new  = sum[PosBits-1:0];
      end else begin
        word_vld = 1'b1;
        cnt_word = sat_inc(word_total_q);
        part_new = wide[2*WordBits-1:WordBits];
        pos_new  = sum[PosBits-1:0];
      end
    end

    word_res.packed_word = partial_q | wide[WordBits-1:0];
    word_res.bits_used   = UsedBits'(WordBits);
    word_res.last_word   = 1'b0;
    word_res.total_words = cnt_word;
    word_res.value_error = 1'b0;
    if (err) begin
      word_res.packed_word = '0;
      word_res.bits_used   = '0;
    end

    fin_vld = 1'b0;
    cnt_fin = cnt_word;
    if (in_data_i.end_of_block) begin
      if (pos_new != '0) begin
        fin_vld = 1'b1;
        cnt_fin = sat_inc(cnt_word);
      end else if (word_vld) begin
        word_res.last_word = 1'b1;
      end else begin
        fin_vld = 1'b1;
      end
    end
    fin_res.packed_word = part_new;
    fin_res.bits_used   = UsedBits'(pos_new);
    fin_res.last_word   = 1'b1;
    fin_res.total_words = cnt_fin;
    fin_res.value_error = err;

    if (err && !in_data_i.end_of_block) begin
      word_vld = 1'b1;
      word_res.value_error = 1'b1;
    end

    if (word_vld) begin
      res_a = word_res;
      res_b = fin_res;
      a_vld = 1'b1;
      b_vld = fin_vld;
    end else begin
      res_a = fin_res;
      res_b = fin_res;
      a_vld = fin_vld;
      b_vld = 1'b0;
    end
    if (!in_fire) begin
      a_vld = 1'b0;
      b_vld = 1'b0;
    end
    push_cnt = QueueCntBits'(a_vld) + QueueCntBits'(b_vld);
    count_d  = count_q + push_cnt - QueueCntBits'(out_fire);

    partial_d    = partial_q;
    bit_pos_d    = bit_pos_q;
    word_total_d = word_total_q;
    if (in_fire) begin
      if (in_data_i.end_of_block) begin
        partial_d    = '0;
        bit_pos_d    = '0;
        word_total_d = '0;
      end else begin
        partial_d    = part_new;
        bit_pos_d    = pos_new;
        word_total_d = cnt_word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q    <= '0;
      bit_pos_q    <= '0;
      word_total_q <= '0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
    end else begin
      partial_q    <= partial_d;
      bit_pos_q    <= bit_pos_d;
      word_total_q <= word_total_d;
      count_q      <= count_d;
      wr_ptr_q     <= wr_ptr_q + QueuePtrBits'(push_cnt);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_vld) begin
      queue_q[wr_ptr_q] <= res_a;
    end
    if (b_vld) begin
      queue_q[wr_ptr_q + QueuePtrBits'(1)] <= res_b;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntBits'(QueueDepth))
    else $error("Output queue count exceeds its depth.");

  a_block_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.end_of_block |=> bit_pos_q == '0 && word_total_q == '0)
    else $error("Packing state not cleared after the end of a block.");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QueuePtrBits'(wr_ptr_q - rd_ptr_q) == count_q[QueuePtrBits-1:0])
    else $error("Queue pointers disagree with the queue count.");

  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_word && !out_data_o.value_error
      |-> out_data_o.bits_used == UsedBits'(WordBits))
    else $error("A word that is not final carries fewer than 32 bits.");

endmodule
